FILE: rtl/wls_pkg.sv
// Shared types and constants for the weather LED show sequencer.
`timescale 1ns / 1ps
`default_nettype none

package wls_pkg;

  // Request command codes
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_ERROR  = 2'd2,
    CMD_SKIP   = 2'd3
  } cmd_t;

  // Show codes: temperature shows equal temp_change, weather shows are weather_kind + 4
  typedef enum logic [3:0] {
    SHOW_NONE          = 4'd0,
    SHOW_MUCH_COLDER   = 4'd1,
    SHOW_LITTLE_COLDER = 4'd2,
    SHOW_LITTLE_WARMER = 4'd3,
    SHOW_MUCH_WARMER   = 4'd4,
    SHOW_CLEAR         = 4'd5,
    SHOW_FEW_CLOUDS    = 4'd6,
    SHOW_CLOUDY        = 4'd7,
    SHOW_SHOWER        = 4'd8,
    SHOW_RAIN          = 4'd9,
    SHOW_THUNDER       = 4'd10,
    SHOW_SNOW          = 4'd11,
    SHOW_FOG           = 4'd12,
    SHOW_ERROR         = 4'd13
  } show_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Light state of the strip: global level plus the even and odd colours
  typedef struct packed {
    logic [7:0] level;
    rgb_t       even_colour;
    rgb_t       odd_colour;
  } lights_t;

  // One computed frame and what it does to the sequencing state
  typedef struct packed {
    lights_t lights;
    logic    show_end;   // show finished, lights back to idle
    logic    restart;    // error loop wrapped, frame counter restarts
  } frame_out_t;

  // Phase counter control, one update per animation step
  typedef struct packed {
    logic load;
    logic to_zero;
    logic to_one;
  } phase_ctl_t;

  typedef logic [15:0] sine_t;

  localparam logic [7:0] LEVEL_FULL = 8'd255;

endpackage

`default_nettype wire

FILE: rtl/wls_sine.sv
// Phase counter and sine table for one animation period.
`timescale 1ns / 1ps
`default_nettype none

module wls_sine #(
  parameter int PERIOD = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wls_pkg::phase_ctl_t ctl,
  output wls_pkg::sine_t           sine
);

  localparam int PW = $clog2(PERIOD);
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // 32768*sin(pi*k/PERIOD) by an eight-term series in Q30, evaluated at elaboration
  function automatic logic [15:0] sine_at(input int unsigned idx);
    longint unsigned k;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned q;
    k = idx;
    if (2 * k > PERIOD) k = PERIOD - k;
    x = (k * PI_Q30) / PERIOD;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    term = ((term * x2) >> 30) / 6;
    sum = (term > sum) ? 64'd0 : sum - term;
    term = ((term * x2) >> 30) / 20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum = (term > sum) ? 64'd0 : sum - term;
    term = ((term * x2) >> 30) / 72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum = (term > sum) ? 64'd0 : sum - term;
    term = ((term * x2) >> 30) / 156;
    sum = sum + term;
    term = ((term * x2) >> 30) / 210;
    sum = (term > sum) ? 64'd0 : sum - term;
    q = (sum + 64'd16384) >> 15;
    if (q > 64'd32768) q = 64'd32768;
    return q[15:0];
  endfunction

  logic [15:0]   rom [2**PW];
  logic [PW-1:0] phase;

  for (genvar i = 0; i < 2**PW; i++) begin : g_rom
    if (i < PERIOD) begin : g_used
      assign rom[i] = sine_at(i);
    end else begin : g_unused
      assign rom[i] = '0;
    end
  end

  // phase tracks frame_counter mod PERIOD
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (ctl.load) begin
      if (ctl.to_zero) begin
        phase <= '0;
      end else if (ctl.to_one) begin
        phase <= PW'(1);
      end else if (phase == PW'(PERIOD - 1)) begin
        phase <= '0;
      end else begin
        phase <= phase + PW'(1);
      end
    end
  end

  assign sine = rom[phase];

endmodule

`default_nettype wire

FILE: rtl/wls_frame.sv
// Frame generator: one animation frame of the running show.
`timescale 1ns / 1ps
`default_nettype none

module wls_frame (
  input  wire wls_pkg::show_t     show,
  input  wire logic [9:0]         frame,
  input  wire logic               queue_busy,
  input  wire wls_pkg::lights_t   lights,
  input  wire wls_pkg::sine_t     sine_fast,
  input  wire wls_pkg::sine_t     sine_slow,
  output wls_pkg::frame_out_t     result
);

  localparam logic [9:0] SHOW_LAST   = 10'd900;
  localparam logic [9:0] TEMP_LAST   = 10'd256;
  localparam logic [9:0] FADE_LONG   = 10'd850;
  localparam logic [9:0] FADE_ERROR  = 10'd400;
  localparam logic [9:0] RISE_LAST   = 10'd127;
  localparam logic [9:0] TEMP_HOLD   = 10'd255;
  localparam int         FLASHES     = 15;

  localparam logic [9:0] FLASH_LO [FLASHES] = '{
    10'd50, 10'd100, 10'd115, 10'd300, 10'd350, 10'd370, 10'd390, 10'd410,
    10'd435, 10'd600, 10'd610, 10'd630, 10'd650, 10'd660, 10'd690
  };
  localparam logic [9:0] FLASH_HI [FLASHES] = '{
    10'd55, 10'd110, 10'd120, 10'd305, 10'd360, 10'd375, 10'd395, 10'd415,
    10'd445, 10'd605, 10'd615, 10'd640, 10'd655, 10'd665, 10'd695
  };

  function automatic wls_pkg::rgb_t mk_rgb(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    wls_pkg::rgb_t c;
    c.r = r;
    c.g = g;
    c.b = b;
    return c;
  endfunction

  // floor(a + (b - a) * s / 32768), never negative
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input wls_pkg::sine_t s);
    logic signed [9:0]  d;
    logic signed [26:0] dx;
    logic signed [26:0] sx;
    logic signed [26:0] t;
    d  = $signed({2'b00, b}) - $signed({2'b00, a});
    dx = 27'(d);
    sx = $signed({11'd0, s});
    t  = $signed({4'd0, a, 15'd0}) + dx * sx;
    return t[22:15];
  endfunction

  // rise over the first frames, fall toward fin, hold elsewhere
  function automatic logic [7:0] fade(input logic [9:0] f, input logic [9:0] fin,
                                      input logic [7:0] lvl);
    logic [10:0] reach;
    logic [9:0]  left;
    reach = {1'b0, f} + {1'b0, RISE_LAST};
    left  = fin - f;
    if (f <= RISE_LAST) begin
      return {f[6:0], 1'b0};
    end else if (reach >= {1'b0, fin} && f <= fin) begin
      return {left[6:0], 1'b0};
    end else begin
      return lvl;
    end
  endfunction

  wls_pkg::rgb_t  temp_colour;
  wls_pkg::rgb_t  grad_a;
  wls_pkg::rgb_t  grad_b;
  wls_pkg::rgb_t  mix;
  wls_pkg::sine_t sine;
  logic           fast;
  logic           flash;
  logic [7:0]     fall;

  always_comb begin
    temp_colour = mk_rgb(8'd0, 8'd0, 8'd0);
    grad_a      = mk_rgb(8'd255, 8'd255, 8'd255);
    grad_b      = mk_rgb(8'd0, 8'd0, 8'd0);
    fast        = 1'b0;
    unique case (show)
      wls_pkg::SHOW_MUCH_COLDER:   temp_colour = mk_rgb(8'd0, 8'd0, 8'd255);
      wls_pkg::SHOW_LITTLE_COLDER: temp_colour = mk_rgb(8'd40, 8'd90, 8'd255);
      wls_pkg::SHOW_LITTLE_WARMER: temp_colour = mk_rgb(8'd255, 8'd90, 8'd65);
      wls_pkg::SHOW_MUCH_WARMER:   temp_colour = mk_rgb(8'd255, 8'd0, 8'd0);
      wls_pkg::SHOW_CLEAR: begin
        grad_a = mk_rgb(8'd255, 8'd130, 8'd10);
        grad_b = mk_rgb(8'd255, 8'd190, 8'd0);
      end
      wls_pkg::SHOW_FEW_CLOUDS: grad_b = mk_rgb(8'd255, 8'd150, 8'd20);
      wls_pkg::SHOW_CLOUDY:     grad_b = mk_rgb(8'd100, 8'd100, 8'd100);
      wls_pkg::SHOW_SHOWER:     grad_b = mk_rgb(8'd25, 8'd25, 8'd255);
      wls_pkg::SHOW_RAIN: begin
        grad_a = mk_rgb(8'd0, 8'd0, 8'd10);
        grad_b = mk_rgb(8'd0, 8'd0, 8'd150);
        fast   = 1'b1;
      end
      wls_pkg::SHOW_SNOW: fast = 1'b1;
      default: ;
    endcase
  end

  assign sine  = fast ? sine_fast : sine_slow;
  assign mix.r = blend(grad_a.r, grad_b.r, sine);
  assign mix.g = blend(grad_a.g, grad_b.g, sine);
  assign mix.b = blend(grad_a.b, grad_b.b, sine);
  assign fall  = 8'(TEMP_HOLD - frame);

  always_comb begin
    flash = 1'b0;
    for (int i = 0; i < FLASHES; i++) begin
      if (frame >= FLASH_LO[i] && frame <= FLASH_HI[i]) flash = 1'b1;
    end
  end

  always_comb begin
    result          = '0;
    result.lights   = lights;
    unique case (show) inside
      wls_pkg::SHOW_MUCH_COLDER, wls_pkg::SHOW_LITTLE_COLDER,
      wls_pkg::SHOW_LITTLE_WARMER, wls_pkg::SHOW_MUCH_WARMER: begin
        if (frame >= TEMP_LAST) begin
          result.show_end = 1'b1;
        end else if (frame <= RISE_LAST) begin
          if (frame == '0) begin
            result.lights.even_colour = temp_colour;
            result.lights.odd_colour  = temp_colour;
          end
          result.lights.level = {frame[6:0], 1'b0};
        end else if (frame < TEMP_HOLD) begin
          result.lights.level = {fall[6:0], 1'b0};
        end
      end
      wls_pkg::SHOW_CLEAR, wls_pkg::SHOW_FEW_CLOUDS, wls_pkg::SHOW_CLOUDY,
      wls_pkg::SHOW_SHOWER, wls_pkg::SHOW_RAIN, wls_pkg::SHOW_SNOW: begin
        if (frame >= SHOW_LAST) begin
          result.show_end = 1'b1;
        end else begin
          if (frame == '0) begin
            result.lights.even_colour = grad_a;
            result.lights.odd_colour  = grad_b;
          end else begin
            result.lights.even_colour = mix;
            result.lights.odd_colour  = mix;
          end
          result.lights.level = fade(frame, FADE_LONG, lights.level);
        end
      end
      wls_pkg::SHOW_FOG: begin
        if (frame >= SHOW_LAST) begin
          result.show_end = 1'b1;
        end else begin
          if (frame == '0) begin
            result.lights.even_colour = mk_rgb(8'd50, 8'd50, 8'd50);
            result.lights.odd_colour  = mk_rgb(8'd50, 8'd50, 8'd50);
          end
          result.lights.level = fade(frame, FADE_LONG, lights.level);
        end
      end
      wls_pkg::SHOW_THUNDER: begin
        if (frame >= SHOW_LAST) begin
          result.show_end = 1'b1;
        end else begin
          result.lights.even_colour = flash ? mk_rgb(8'd255, 8'd255, 8'd255) : '0;
          result.lights.odd_colour  = flash ? mk_rgb(8'd255, 8'd255, 8'd255) : '0;
        end
      end
      wls_pkg::SHOW_ERROR: begin
        if (queue_busy) begin
          result.show_end = 1'b1;
        end else if (frame >= SHOW_LAST) begin
          result.restart = 1'b1;
        end else begin
          if (frame == '0) begin
            result.lights.even_colour = mk_rgb(8'd255, 8'd0, 8'd0);
            result.lights.odd_colour  = mk_rgb(8'd255, 8'd0, 8'd0);
          end
          result.lights.level = fade(frame, FADE_ERROR, lights.level);
        end
      end
      default: result.show_end = 1'b1;
    endcase
    // ending a show drops the strip back to idle
    if (result.show_end) begin
      result.lights.level       = wls_pkg::LEVEL_FULL;
      result.lights.even_colour = '0;
      result.lights.odd_colour  = '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/weather_led_show_sequencer.sv
// Top level of the weather LED show sequencer: request register, sequencing state, result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_data (update_interval)
// in        in         in_valid / in_ready    cmd, temp_change, weather_kind
// out       out        out_valid / out_ready  brightness, even_*, odd_*
//
// One request per cycle while no result waits untaken; a request that emits a frame
// goes from the request register through the frame logic and state update into the
// result register. The path is the sine table, one 10x17 blend multiply and an add.
// Reset clears the sequencing state to idle (full level, dark strip) and loads update_interval with 20;
// cfg_ready is always high. A result that is not taken holds the request register, and
// in_ready drops only while both the request register and the result register are full.

module weather_led_show_sequencer #(
  parameter int FAST_PERIOD = 64,
  parameter int SLOW_PERIOD = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [2:0]  temp_change,
  input  wire logic [3:0]  weather_kind,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       brightness,
  output logic [7:0]       even_red,
  output logic [7:0]       even_green,
  output logic [7:0]       even_blue,
  output logic [7:0]       odd_red,
  output logic [7:0]       odd_green,
  output logic [7:0]       odd_blue
);

  localparam logic [15:0] INTERVAL_RESET = 16'd20;

  typedef struct packed {
    wls_pkg::show_t first;
    wls_pkg::show_t second;
  } queue_t;

  // Enqueue into the two-slot queue; a full queue keeps only the newest show
  function automatic queue_t enqueue(input queue_t q, input wls_pkg::show_t s);
    queue_t r;
    r = q;
    if (q.first != wls_pkg::SHOW_NONE && q.second != wls_pkg::SHOW_NONE) begin
      r.first  = s;
      r.second = wls_pkg::SHOW_NONE;
    end else if (q.first != wls_pkg::SHOW_NONE) begin
      r.second = s;
    end else begin
      r.first = s;
    end
    return r;
  endfunction

  // Configuration register
  logic [15:0] update_interval;

  // Request register
  logic              req_valid;
  wls_pkg::cmd_t     req_cmd;
  logic [2:0]        req_temp;
  logic [3:0]        req_kind;

  // Sequencing state
  logic [15:0]       elapsed_ticks;
  logic [9:0]        frame_counter;
  wls_pkg::show_t    current_show;
  wls_pkg::show_t    queued_first;
  wls_pkg::show_t    queued_second;
  logic [7:0]        level;
  wls_pkg::rgb_t     even_colour;
  wls_pkg::rgb_t     odd_colour;

  logic [15:0]       elapsed_ticks_next;
  logic [9:0]        frame_counter_next;
  wls_pkg::show_t    current_show_next;
  wls_pkg::show_t    queued_first_next;
  wls_pkg::show_t    queued_second_next;
  wls_pkg::lights_t  lights_next;
  logic              emit;

  // Result register
  wls_pkg::lights_t  out_lights;

  logic              fire;
  logic [16:0]       tick_count;
  logic              update_due;
  logic              dequeue;
  wls_pkg::show_t    show_now;
  wls_pkg::show_t    queue_head;
  logic [9:0]        base_frame;
  wls_pkg::lights_t  lights;
  wls_pkg::frame_out_t frame_out;
  wls_pkg::phase_ctl_t phase_ctl;
  wls_pkg::sine_t    sine_fast;
  wls_pkg::sine_t    sine_slow;
  queue_t            queue_now;
  queue_t            queue_tmp;

  // Advance the request when the result register is free or being emptied
  assign fire      = req_valid && (!out_valid || out_ready);
  assign in_ready  = !req_valid || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_interval <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      update_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_valid <= 1'b1;
    end else if (fire) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_cmd  <= wls_pkg::cmd_t'(cmd);
      req_temp <= temp_change;
      req_kind <= weather_kind;
    end
  end

  // An update fires on the tick that makes elapsed_ticks exceed the interval
  assign tick_count = {1'b0, elapsed_ticks} + 17'd1;
  assign update_due = tick_count > {1'b0, update_interval};

  // With nothing running, an update first pulls the next show from the queue at frame 0
  assign dequeue    = current_show == wls_pkg::SHOW_NONE;
  assign show_now   = dequeue ? queued_first : current_show;
  assign queue_head = dequeue ? queued_second : queued_first;
  assign base_frame = dequeue ? 10'd0 : frame_counter;

  assign lights.level       = level;
  assign lights.even_colour = even_colour;
  assign lights.odd_colour  = odd_colour;

  assign queue_now.first  = queued_first;
  assign queue_now.second = queued_second;

  wls_frame u_frame (
    .show       (show_now),
    .frame      (base_frame),
    .queue_busy (queue_head != wls_pkg::SHOW_NONE),
    .lights     (lights),
    .sine_fast  (sine_fast),
    .sine_slow  (sine_slow),
    .result     (frame_out)
  );

  wls_sine #(.PERIOD(FAST_PERIOD)) u_sine_fast (
    .clk  (clk),
    .rst  (rst),
    .ctl  (phase_ctl),
    .sine (sine_fast)
  );

  wls_sine #(.PERIOD(SLOW_PERIOD)) u_sine_slow (
    .clk  (clk),
    .rst  (rst),
    .ctl  (phase_ctl),
    .sine (sine_slow)
  );

  always_comb begin
    elapsed_ticks_next = elapsed_ticks;
    frame_counter_next = frame_counter;
    current_show_next  = current_show;
    queued_first_next  = queued_first;
    queued_second_next = queued_second;
    lights_next        = lights;
    emit               = 1'b0;
    phase_ctl          = '0;
    queue_tmp          = queue_now;
    if (fire) begin
      unique case (req_cmd)
        wls_pkg::CMD_TICK: begin
          if (!update_due) begin
            elapsed_ticks_next = tick_count[15:0];
          end else begin
            elapsed_ticks_next = '0;
            if (dequeue) begin
              queued_first_next  = queued_second;
              queued_second_next = wls_pkg::SHOW_NONE;
            end
            current_show_next = show_now;
            if (show_now == wls_pkg::SHOW_NONE) begin
              // idle update: frame counter parks at 0, nothing is emitted
              frame_counter_next = '0;
            end else begin
              emit        = 1'b1;
              lights_next = frame_out.lights;
              if (frame_out.show_end) current_show_next = wls_pkg::SHOW_NONE;
              frame_counter_next = frame_out.restart ? 10'd1 : base_frame + 10'd1;
            end
            phase_ctl.load    = 1'b1;
            phase_ctl.to_zero = frame_counter_next == '0;
            phase_ctl.to_one  = dequeue || frame_out.restart;
          end
        end
        wls_pkg::CMD_REPORT: begin
          if (req_temp >= 3'd1 && req_temp <= 3'd4) begin
            queue_tmp = enqueue(queue_tmp, wls_pkg::show_t'({1'b0, req_temp}));
          end
          if (req_kind >= 4'd1 && req_kind <= 4'd8) begin
            queue_tmp = enqueue(queue_tmp, wls_pkg::show_t'(req_kind + 4'd4));
          end
          queued_first_next  = queue_tmp.first;
          queued_second_next = queue_tmp.second;
        end
        wls_pkg::CMD_ERROR: begin
          // start the red loop at the current frame, drop anything queued
          current_show_next  = wls_pkg::SHOW_ERROR;
          queued_first_next  = wls_pkg::SHOW_NONE;
          queued_second_next = wls_pkg::SHOW_NONE;
        end
        wls_pkg::CMD_SKIP: begin
          queue_tmp          = enqueue(queue_tmp, wls_pkg::SHOW_NONE);
          queued_first_next  = queue_tmp.first;
          queued_second_next = queue_tmp.second;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ticks <= '0;
      frame_counter <= '0;
      current_show  <= wls_pkg::SHOW_NONE;
      queued_first  <= wls_pkg::SHOW_NONE;
      queued_second <= wls_pkg::SHOW_NONE;
      level         <= wls_pkg::LEVEL_FULL;
      even_colour   <= '0;
      odd_colour    <= '0;
    end else begin
      elapsed_ticks <= elapsed_ticks_next;
      frame_counter <= frame_counter_next;
      current_show  <= current_show_next;
      queued_first  <= queued_first_next;
      queued_second <= queued_second_next;
      level         <= lights_next.level;
      even_colour   <= lights_next.even_colour;
      odd_colour    <= lights_next.odd_colour;
    end
  end

  // Result register: load on an emitted frame, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_lights <= lights_next;
  end

  assign brightness = out_lights.level;
  assign even_red   = out_lights.even_colour.r;
  assign even_green = out_lights.even_colour.g;
  assign even_blue  = out_lights.even_colour.b;
  assign odd_red    = out_lights.odd_colour.r;
  assign odd_green  = out_lights.odd_colour.g;
  assign odd_blue   = out_lights.odd_colour.b;

  // A new result appears only from a request that advanced
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire))
    else $error("result appeared without an advancing request");

  // The second queue slot is never filled while the first is empty
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    queued_second != wls_pkg::SHOW_NONE |-> queued_first != wls_pkg::SHOW_NONE)
    else $error("queue holds a second show without a first");

  // With no show running the strip sits at full level and dark
  a_idle_lights: assert property (@(posedge clk) disable iff (rst)
    current_show == wls_pkg::SHOW_NONE |->
      (level == wls_pkg::LEVEL_FULL && even_colour == '0 && odd_colour == '0))
    else $error("idle sequencer holds stale lights");

endmodule

`default_nettype wire
